/* rtl/core/wss_pkg.sv */
// Package for the wildcard signature scan core.
// Holds the request and response payload types, the scan configuration type and the
// register index constants. It depends on nothing else.
package wss_pkg;

   localparam int ADDR_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 6;
   localparam int SIG_WORD_W  = 64;
   localparam int SIG_WORDS   = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'hff;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_LENGTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_WORD_0   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_WORD_1   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_WORD_2   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIG_WORD_3   = 3'd5;

   typedef struct packed {
      logic [BYTE_W-1:0] mem_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base_address;
      logic [LEN_W-1:0]  sig_length;
   } scan_cfg_type;

endpackage

/* rtl/core/wss_csr.sv */
// Configuration registers of the wildcard signature scan core.
// Holds base address, signature length and signature words, and clamps the length.
// Depends on wss_pkg.
module wss_csr #(
   parameter int MAX_SIG_BYTES = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [wss_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [wss_pkg::CSR_DATA_W-1:0]         csr_wdata,
   output wss_pkg::scan_cfg_type                  cfg,
   output logic [MAX_SIG_BYTES*wss_pkg::BYTE_W-1:0] sig_bytes
);

   localparam logic [wss_pkg::LEN_W-1:0] LEN_MAX = wss_pkg::LEN_W'(MAX_SIG_BYTES);

   logic [wss_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [wss_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [wss_pkg::SIG_WORDS-1:0][wss_pkg::SIG_WORD_W-1:0] sig_words_ff, sig_words_in;
   logic [wss_pkg::SIG_WORDS*wss_pkg::SIG_WORD_W-1:0]      sig_flat;
   logic [1:0] word_sel;

   assign word_sel = 2'(csr_index - wss_pkg::CSR_SIG_WORD_0);

   always_comb begin
      base_in      = base_ff;
      len_in       = len_ff;
      sig_words_in = sig_words_ff;
      if (csr_write) begin
         case (csr_index)
            wss_pkg::CSR_BASE_ADDRESS: base_in = csr_wdata[wss_pkg::ADDR_W-1:0];
            wss_pkg::CSR_SIG_LENGTH:   len_in  = csr_wdata[wss_pkg::LEN_W-1:0];
            wss_pkg::CSR_SIG_WORD_0,
            wss_pkg::CSR_SIG_WORD_1,
            wss_pkg::CSR_SIG_WORD_2,
            wss_pkg::CSR_SIG_WORD_3:   sig_words_in[word_sel] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         len_ff       <= wss_pkg::LEN_W'(1);
         sig_words_ff <= '0;
      end else begin
         base_ff      <= base_in;
         len_ff       <= len_in;
         sig_words_ff <= sig_words_in;
      end
   end

   assign cfg.base_address = base_ff;
   assign cfg.sig_length   = (len_ff > LEN_MAX) ? LEN_MAX : len_ff;
   assign sig_flat         = sig_words_ff;
   assign sig_bytes        = sig_flat[MAX_SIG_BYTES*wss_pkg::BYTE_W-1:0];

endmodule

/* rtl/core/wss_match.sv */
// Per-position byte compare of the wildcard signature scan core.
// Builds the match mask of one byte against all signature bytes in use and the tail select.
// Depends on wss_pkg.
module wss_match #(
   parameter int MAX_SIG_BYTES = 32
) (
   input  logic [wss_pkg::BYTE_W-1:0]               mem_byte,
   input  logic [MAX_SIG_BYTES*wss_pkg::BYTE_W-1:0] sig_bytes,
   input  logic [wss_pkg::LEN_W-1:0]                sig_length,
   output logic [MAX_SIG_BYTES-1:0]                 match_mask,
   output logic [MAX_SIG_BYTES-1:0]                 tail_sel
);

   always_comb begin
      for (int k = 0; k < MAX_SIG_BYTES; k++) begin
         match_mask[k] = ((sig_bytes[k*wss_pkg::BYTE_W +: wss_pkg::BYTE_W]
                           == wss_pkg::WILDCARD_BYTE)
                          || (sig_bytes[k*wss_pkg::BYTE_W +: wss_pkg::BYTE_W] == mem_byte))
                         && (wss_pkg::LEN_W'(k) < sig_length);
         tail_sel[k]   = (sig_length == wss_pkg::LEN_W'(k + 1));
      end
   end

endmodule

/* rtl/core/wss_scan.sv */
// Scan state and response register of the wildcard signature scan core.
// Updates the partial match vector, byte offset and found flag and forms the response.
// Depends on wss_pkg.
module wss_scan #(
   parameter int MAX_SIG_BYTES = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stage_valid,
   input  wss_pkg::req_type         stage_req,
   input  wss_pkg::scan_cfg_type    cfg,
   input  logic [MAX_SIG_BYTES-1:0] match_mask,
   input  logic [MAX_SIG_BYTES-1:0] tail_sel,
   input  logic                     rsp_stall,
   output logic                     advance,
   output logic                     rsp_valid,
   output wss_pkg::rsp_type         rsp_data
);

   logic [MAX_SIG_BYTES-1:0]   pvec_ff, pvec_in, pvec_shift;
   logic [wss_pkg::ADDR_W-1:0] offset_ff, offset_in;
   logic                       found_ff, found_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   wss_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       step;
   logic                       len_zero;
   logic                       hit;
   logic [wss_pkg::ADDR_W-1:0] hit_address;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign step       = stage_valid && advance;
   assign len_zero   = (cfg.sig_length == '0);
   assign pvec_shift = ((pvec_ff << 1) | MAX_SIG_BYTES'(1)) & match_mask;
   assign hit        = len_zero || (|(pvec_shift & tail_sel));
   assign hit_address = cfg.base_address + offset_ff - wss_pkg::ADDR_W'(cfg.sig_length)
                        + (len_zero ? wss_pkg::ADDR_W'(0) : wss_pkg::ADDR_W'(1));

   always_comb begin
      pvec_in      = pvec_ff;
      offset_in    = offset_ff;
      found_in     = found_ff;
      rsp_valid_in = advance ? 1'b0 : rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (step) begin
         if (!found_ff) begin
            if (!len_zero) begin
               pvec_in = pvec_shift;
            end
            if (hit) begin
               found_in             = 1'b1;
               rsp_valid_in         = 1'b1;
               rsp_in.found         = 1'b1;
               rsp_in.match_address = hit_address;
            end else if (stage_req.last_byte) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
            end
         end
         offset_in = offset_ff + wss_pkg::ADDR_W'(1);
         if (stage_req.last_byte) begin
            pvec_in   = '0;
            offset_in = '0;
            found_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvec_ff      <= '0;
         offset_ff    <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pvec_ff      <= pvec_in;
         offset_ff    <= offset_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      $past(step && stage_req.last_byte) |-> (offset_ff == '0) && (pvec_ff == '0) && !found_ff)
      else $error("scan state not cleared after the last byte of a range");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |-> (rsp_ff.match_address == '0))
      else $error("not-found response carries a nonzero address");

   a_found_reports: assert property (@(posedge clock) disable iff (reset)
      $rose(found_ff) |-> rsp_valid_ff && rsp_ff.found)
      else $error("match recorded without a found response");

   a_silent_after_found: assert property (@(posedge clock) disable iff (reset)
      found_ff && step && !stage_req.last_byte |=> !rsp_valid_ff)
      else $error("response produced after a match in the same range");

endmodule

/* rtl/core/wildcard_signature_scan_core.sv */
// Wildcard signature scan core: one request carries one byte of a memory range, so
// a byte is accepted every cycle while the response side keeps up. A request is held
// in the input register and its response, if any, is registered in the response
// register; the per-byte update of the partial match vector sets this rate.
// Registers may be written at any time the core is idle, and no clearing pass
// follows reset.
module wildcard_signature_scan_core #(
   parameter int MAX_SIG_BYTES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  wss_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output wss_pkg::rsp_type                rsp_data,
   input  logic                            csr_write,
   input  logic [wss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wss_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                                     stage_valid_ff, stage_valid_in;
   wss_pkg::req_type                         stage_req_ff, stage_req_in;
   logic                                     advance;
   logic                                     req_accept;
   wss_pkg::scan_cfg_type                    cfg;
   logic [MAX_SIG_BYTES*wss_pkg::BYTE_W-1:0] sig_bytes;
   logic [MAX_SIG_BYTES-1:0]                 match_mask;
   logic [MAX_SIG_BYTES-1:0]                 tail_sel;

   assign req_stall  = stage_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_req_in   = stage_req_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
         stage_req_in   = req_data;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_req_ff <= stage_req_in;
   end

   wss_csr #(.MAX_SIG_BYTES(MAX_SIG_BYTES)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .sig_bytes (sig_bytes)
   );

   wss_match #(.MAX_SIG_BYTES(MAX_SIG_BYTES)) u_match (
      .mem_byte   (stage_req_ff.mem_byte),
      .sig_bytes  (sig_bytes),
      .sig_length (cfg.sig_length),
      .match_mask (match_mask),
      .tail_sel   (tail_sel)
   );

   wss_scan #(.MAX_SIG_BYTES(MAX_SIG_BYTES)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid_ff),
      .stage_req   (stage_req_ff),
      .cfg         (cfg),
      .match_mask  (match_mask),
      .tail_sel    (tail_sel),
      .rsp_stall   (rsp_stall),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule
